### design/ppm6_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary PPM stream decoder.
// Depends on nothing; the decoder and its checker use it by scoped names.
package ppm6_pkg;

	// One input transaction: a raw file byte and its end-of-file mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} byte_t;

	// One result transaction: a pixel, an accepted header or an error.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic        last_pixel;
		logic [2:0]  error_code;
	} result_t;

	// Result kinds.
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_NUMBER    = 3'd2;
	localparam logic [2:0] ERR_MAXVAL    = 3'd3;
	localparam logic [2:0] ERR_SIZE      = 3'd4;
	localparam logic [2:0] ERR_SEPARATOR = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED = 3'd6;

	// Characters and values the parser looks for.
	localparam logic [7:0] CHAR_P       = 8'h50;
	localparam logic [7:0] CHAR_SIX     = 8'h36;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] FULL_MAXVAL  = 8'd255;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

endpackage

### design/ppm_p6_stream_decoder.sv
`timescale 1ns / 1ps
// Binary PPM (P6) stream decoder: header parser, size checks and pixel packer.
// Depends on ppm6_pkg for the transaction types, codes and characters.
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a waiting result is stalled; each byte is one
// update of the parser state registers. The width times height product is registered from the held width and height.
// Reset (arst_n low) clears the parser to "expecting magic" and empties the output register.
// A byte carrying end_of_file also returns the parser to that state after its own result.
module ppm_p6_stream_decoder #(
	parameter int DIMENSION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  ppm6_pkg::byte_t   byte_data,
	output logic              result_valid,
	input  logic              result_stall,
	output ppm6_pkg::result_t result_data
);

	localparam int DW = DIMENSION_BITS;
	localparam int AW = DIMENSION_BITS + 4;

	// Parser phases.
	localparam logic [2:0] PH_MAGIC  = 3'd0;
	localparam logic [2:0] PH_WIDTH  = 3'd1;
	localparam logic [2:0] PH_HEIGHT = 3'd2;
	localparam logic [2:0] PH_MAXVAL = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_WAIT   = 3'd5;

	logic [2:0]      phase_q;
	logic            in_comment_q;
	logic [4:0]      token_position_q;
	logic [DW-1:0]   number_accumulator_q;
	logic            number_overflow_q;
	logic            token_bad_q;
	logic            digit_seen_q;
	logic [DW-1:0]   width_held_q;
	logic [DW-1:0]   height_held_q;
	logic [DW-1:0]   pixels_remaining_q;
	logic [1:0]      component_index_q;
	logic [7:0]      red_held_q;
	logic [7:0]      green_held_q;
	logic [2*DW-1:0] area_q;
	logic            result_valid_q;
	ppm6_pkg::result_t result_q;

	// Next-state values.
	logic [2:0]      phase_d;
	logic            in_comment_d;
	logic [4:0]      token_position_d;
	logic [DW-1:0]   number_accumulator_d;
	logic            number_overflow_d;
	logic            token_bad_d;
	logic            digit_seen_d;
	logic [DW-1:0]   width_held_d;
	logic [DW-1:0]   height_held_d;
	logic [DW-1:0]   pixels_remaining_d;
	logic [1:0]      component_index_d;
	logic [7:0]      red_held_d;
	logic [7:0]      green_held_d;
	logic            fire;
	ppm6_pkg::result_t result_d;

	logic accept;
	logic area_overflow;

	// A byte is taken whenever the output register is empty or being drained.
	assign byte_stall   = result_valid_q & result_stall;
	assign accept       = byte_valid & ~byte_stall;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign area_overflow = |area_q[2*DW-1:DW];

	// Parser step for one accepted byte.
	always_comb begin
		logic [7:0]    b;
		logic          eof;
		logic          is_space;
		logic          add;
		logic          fin;
		logic          fin_space;
		logic          ended;
		logic          last;
		logic          bad;
		logic [4:0]    pos;
		logic [AW-1:0] grown;
		logic [DW-1:0] val;

		b         = byte_data.data_byte;
		eof       = byte_data.end_of_file;
		is_space  = (b == ppm6_pkg::CHAR_SPACE) ||
		            ((b >= ppm6_pkg::CHAR_TAB) && (b <= ppm6_pkg::CHAR_CR));
		add       = 1'b0;
		fin       = 1'b0;
		fin_space = 1'b0;
		ended     = 1'b0;
		last      = 1'b0;
		bad       = 1'b0;
		pos       = token_position_q;
		grown     = '0;
		val       = '0;

		phase_d              = phase_q;
		in_comment_d         = in_comment_q;
		token_position_d     = token_position_q;
		number_accumulator_d = number_accumulator_q;
		number_overflow_d    = number_overflow_q;
		token_bad_d          = token_bad_q;
		digit_seen_d         = digit_seen_q;
		width_held_d         = width_held_q;
		height_held_d        = height_held_q;
		pixels_remaining_d   = pixels_remaining_q;
		component_index_d    = component_index_q;
		red_held_d           = red_held_q;
		green_held_d         = green_held_q;
		fire                 = 1'b0;
		result_d             = '0;

		case (phase_q)
			PH_WAIT: begin
			end
			PH_DATA: begin
				// Gather three components, then emit an opaque pixel.
				case (component_index_q)
					2'd0: begin
						red_held_d        = b;
						component_index_d = 2'd1;
					end
					2'd1: begin
						green_held_d      = b;
						component_index_d = 2'd2;
					end
					default: begin
						component_index_d   = 2'd0;
						pixels_remaining_d  = pixels_remaining_q - DW'(1);
						last                = (pixels_remaining_q == DW'(1));
						fire                = 1'b1;
						result_d.kind       = ppm6_pkg::KIND_PIXEL;
						result_d.red        = red_held_q;
						result_d.green      = green_held_q;
						result_d.blue       = b;
						result_d.alpha      = ppm6_pkg::ALPHA_OPAQUE;
						result_d.last_pixel = last;
						if (last) begin
							phase_d = PH_WAIT;
						end
					end
				endcase
				if (eof && !last) begin
					fire                = 1'b1;
					result_d            = '0;
					result_d.kind       = ppm6_pkg::KIND_ERROR;
					result_d.error_code = ppm6_pkg::ERR_TRUNCATED;
				end
			end
			default: begin
				// Header: comments, whitespace and token boundaries.
				if (in_comment_q) begin
					if (b == ppm6_pkg::CHAR_NEWLINE) begin
						in_comment_d = 1'b0;
					end
				end else if (token_position_q == 5'd0) begin
					if (b == ppm6_pkg::CHAR_HASH) begin
						in_comment_d = 1'b1;
					end else if (!is_space) begin
						add = 1'b1;
					end
				end else if (is_space) begin
					fin       = 1'b1;
					fin_space = 1'b1;
					ended     = 1'b1;
				end else begin
					add = 1'b1;
				end

				// Append one character to the current token.
				if (add) begin
					if (token_position_q != 5'd31) begin
						token_position_d = token_position_q + 5'd1;
					end
					if (phase_q == PH_MAGIC) begin
						if ((pos == 5'd0 && b != ppm6_pkg::CHAR_P) ||
						    (pos == 5'd1 && b != ppm6_pkg::CHAR_SIX) || (pos >= 5'd2)) begin
							token_bad_d = 1'b1;
						end
					end else if (b >= ppm6_pkg::CHAR_ZERO && b <= ppm6_pkg::CHAR_NINE) begin
						grown        = AW'(number_accumulator_q) * AW'(10) + AW'(b[3:0]);
						digit_seen_d = 1'b1;
						if (|grown[AW-1:DW]) begin
							number_overflow_d = 1'b1;
						end else begin
							number_accumulator_d = grown[DW-1:0];
						end
					end else if (!(b == ppm6_pkg::CHAR_PLUS && pos == 5'd0)) begin
						token_bad_d = 1'b1;
					end
				end

				// A token cut short by end of file still ends here.
				if (eof && !ended && token_position_d != 5'd0) begin
					fin = 1'b1;
				end

				// Close the token and run the header checks.
				if (fin) begin
					val = number_accumulator_d;
					if (phase_q == PH_MAGIC) begin
						bad = token_bad_d || (token_position_d != 5'd2);
					end else begin
						bad = token_bad_d || number_overflow_d || !digit_seen_d;
					end
					token_position_d     = 5'd0;
					number_accumulator_d = '0;
					number_overflow_d    = 1'b0;
					token_bad_d          = 1'b0;
					digit_seen_d         = 1'b0;
					result_d.kind        = ppm6_pkg::KIND_ERROR;
					if (phase_q == PH_MAGIC) begin
						if (bad) begin
							fire                = 1'b1;
							result_d.error_code = ppm6_pkg::ERR_MAGIC;
						end else begin
							phase_d = PH_WIDTH;
						end
					end else if (bad) begin
						fire                = 1'b1;
						result_d.error_code = ppm6_pkg::ERR_NUMBER;
					end else if (phase_q == PH_WIDTH) begin
						width_held_d = val;
						phase_d      = PH_HEIGHT;
					end else if (phase_q == PH_HEIGHT) begin
						height_held_d = val;
						phase_d       = PH_MAXVAL;
					end else if (val != DW'(ppm6_pkg::FULL_MAXVAL)) begin
						fire                = 1'b1;
						result_d.error_code = ppm6_pkg::ERR_MAXVAL;
					end else if (width_held_q == '0 || height_held_q == '0 ||
					             area_overflow) begin
						fire                = 1'b1;
						result_d.error_code = ppm6_pkg::ERR_SIZE;
					end else if (!fin_space) begin
						fire                = 1'b1;
						result_d.error_code = ppm6_pkg::ERR_SEPARATOR;
					end else begin
						pixels_remaining_d    = area_q[DW-1:0];
						component_index_d     = 2'd0;
						phase_d               = PH_DATA;
						fire                  = 1'b1;
						result_d.kind         = ppm6_pkg::KIND_HEADER;
						result_d.image_width  = 32'(width_held_q);
						result_d.image_height = 32'(height_held_q);
					end
					if (!fire) begin
						result_d = '0;
					end
				end

				// End of file inside the header, or right on the separator.
				if (eof) begin
					if (!fire) begin
						fire          = 1'b1;
						result_d      = '0;
						result_d.kind = ppm6_pkg::KIND_ERROR;
						result_d.error_code = (phase_d == PH_MAGIC) ?
						                      ppm6_pkg::ERR_MAGIC : ppm6_pkg::ERR_NUMBER;
					end else if (phase_d == PH_DATA) begin
						result_d            = '0;
						result_d.kind       = ppm6_pkg::KIND_ERROR;
						result_d.error_code = ppm6_pkg::ERR_TRUNCATED;
					end
				end
				if (fire) begin
					if (result_d.kind == ppm6_pkg::KIND_ERROR) begin
						phase_d = PH_WAIT;
					end
				end
			end
		endcase

		// The final byte of a file restarts the parser.
		if (eof) begin
			phase_d              = PH_MAGIC;
			in_comment_d         = 1'b0;
			token_position_d     = 5'd0;
			number_accumulator_d = '0;
			number_overflow_d    = 1'b0;
			token_bad_d          = 1'b0;
			digit_seen_d         = 1'b0;
			width_held_d         = '0;
			height_held_d        = '0;
			pixels_remaining_d   = '0;
			component_index_d    = 2'd0;
			red_held_d           = '0;
			green_held_d         = '0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q              <= PH_MAGIC;
			in_comment_q         <= 1'b0;
			token_position_q     <= 5'd0;
			number_accumulator_q <= '0;
			number_overflow_q    <= 1'b0;
			token_bad_q          <= 1'b0;
			digit_seen_q         <= 1'b0;
			width_held_q         <= '0;
			height_held_q        <= '0;
			pixels_remaining_q   <= '0;
			component_index_q    <= 2'd0;
			red_held_q           <= '0;
			green_held_q         <= '0;
		end else if (accept) begin
			phase_q              <= phase_d;
			in_comment_q         <= in_comment_d;
			token_position_q     <= token_position_d;
			number_accumulator_q <= number_accumulator_d;
			number_overflow_q    <= number_overflow_d;
			token_bad_q          <= token_bad_d;
			digit_seen_q         <= digit_seen_d;
			width_held_q         <= width_held_d;
			height_held_q        <= height_held_d;
			pixels_remaining_q   <= pixels_remaining_d;
			component_index_q    <= component_index_d;
			red_held_q           <= red_held_d;
			green_held_q         <= green_held_d;
		end
	end

	// Image area, ready well before the maxval token can end.
	always_ff @(posedge clk) begin
		area_q <= (2*DW)'(width_held_q) * (2*DW)'(height_held_q);
	end

	// Output register: loaded on a firing transaction, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= fire;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fire) begin
			result_q <= result_d;
		end
	end

endmodule

### design/ppm6_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the PPM stream decoder, bound to its top level.
// Depends on ppm6_pkg and on ppm_p6_stream_decoder.
module ppm6_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              byte_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ppm6_pkg::result_t result_data
);

	// A waiting result keeps its contents until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
	else $error("result changed while stalled");

	// Input is held back only by a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid && result_stall)
	else $error("input stalled without a waiting result");

	// Pixels are always opaque.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind == ppm6_pkg::KIND_PIXEL
		|-> result_data.alpha == ppm6_pkg::ALPHA_OPAQUE)
	else $error("pixel alpha not opaque");

	// An error transaction carries a real error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind == ppm6_pkg::KIND_ERROR
		|-> result_data.error_code != ppm6_pkg::ERR_NONE &&
		    result_data.error_code <= ppm6_pkg::ERR_TRUNCATED)
	else $error("error transaction without a valid code");

	// An accepted header never has a zero size.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind == ppm6_pkg::KIND_HEADER
		|-> result_data.image_width != 32'd0 && result_data.image_height != 32'd0)
	else $error("header with zero size");

endmodule

bind ppm_p6_stream_decoder ppm6_checker u_ppm6_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_stall   (byte_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);
